// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, reset-gated, reporting by $error
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bbht_pkg.sv
// ----------------------------------------------------------------------------
// bbht_pkg
// shared constants and types of the bounded bucket hash table
// ----------------------------------------------------------------------------
`default_nettype none

package bbht_pkg;

    localparam int INDEX_BITS_DEF  = 16;
    localparam int CHAIN_LIMIT_DEF = 3;

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 64;
    localparam int DEPTH_W = 6;
    localparam int TYPE_W  = 2;
    localparam int INFO_W  = DEPTH_W + TYPE_W;

    localparam logic KIND_STORE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_ENT_RD,
        ST_ENT_CMP,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// File: design/bbht_in_if.sv
// ----------------------------------------------------------------------------
// bbht_in_if
// request channel: store or lookup transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface bbht_in_if import bbht_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [MOVE_W-1:0]  best_move;
    logic [DEPTH_W-1:0] search_depth;
    logic [TYPE_W-1:0]  bound_type;

    modport source (
        output valid, kind, key, best_move, search_depth, bound_type,
        input  ready
    );

    modport sink (
        input  valid, kind, key, best_move, search_depth, bound_type,
        output ready
    );

endinterface

`default_nettype wire

// File: design/bbht_out_if.sv
// ----------------------------------------------------------------------------
// bbht_out_if
// response channel: lookup results
// ----------------------------------------------------------------------------
`default_nettype none

interface bbht_out_if import bbht_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               hit;
    logic [MOVE_W-1:0]  found_move;
    logic [DEPTH_W-1:0] found_depth;
    logic [TYPE_W-1:0]  found_type;

    modport source (
        output valid, hit, found_move, found_depth, found_type,
        input  ready
    );

    modport sink (
        input  valid, hit, found_move, found_depth, found_type,
        output ready
    );

endinterface

`default_nettype wire

// File: design/bbht_ram.sv
// ----------------------------------------------------------------------------
// bbht_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bbht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/bounded_bucket_hash_table.sv
// ----------------------------------------------------------------------------
// bounded_bucket_hash_table
// bucketed position-hash table keeping the newest CHAIN_LIMIT+1 entries per
// bucket; stores push at the bucket head, lookups scan newest to oldest
// ----------------------------------------------------------------------------
//
//  channel | dir | transaction          | payload
//  --------+-----+----------------------+------------------------------------
//  req     | in  | store or lookup      | kind, key, best_move, search_depth,
//          |     |                      | bound_type
//  rsp     | out | one per lookup only  | hit, found_move, found_depth,
//          |     |                      | found_type
//
//  store: accept, then bucket metadata read and write-back
//  lookup: metadata read, then entry read and tag compare for n ways in turn,
//    n = 0..CHAIN_LIMIT+1, by the single tag comparator and one entry read port
//  after reset a clearing pass zeroes every bucket's metadata, one bucket a
//    cycle, with req.ready low throughout
//  a result waits in the rsp register; req is taken again once it is loaded
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_bucket_hash_table import bbht_pkg::*; #(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int CHAIN_LIMIT = CHAIN_LIMIT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bbht_in_if.sink     req,
    bbht_out_if.source  rsp
);

    // geometry
    localparam int WAYS       = CHAIN_LIMIT + 1;
    localparam int WAY_W      = $clog2(WAYS);
    localparam int FILL_W     = $clog2(WAYS + 1);
    localparam int TAG_W      = KEY_W - INDEX_BITS;
    localparam int META_W     = FILL_W + WAY_W;
    localparam int ENT_W      = TAG_W + MOVE_W + INFO_W;
    localparam int ENT_ADDR_W = INDEX_BITS + WAY_W;
    localparam int BUCKETS    = 1 << INDEX_BITS;
    localparam int ENT_DEPTH  = 1 << ENT_ADDR_W;

    localparam logic [WAY_W:0]  WAYS_EXT  = (WAY_W + 1)'(WAYS);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
    localparam logic [FILL_W-1:0] FULL    = FILL_W'(WAYS);

    // control state
    state_t                  state_reg,   state_next;
    logic [INDEX_BITS-1:0]   clr_idx_reg, clr_idx_next;
    logic [WAY_W-1:0]        head_reg,    head_next;
    logic [FILL_W-1:0]       fill_reg,    fill_next;
    logic [WAY_W-1:0]        idx_reg,     idx_next;
    logic                    hit_reg,     hit_next;
    logic                    out_valid_reg, out_valid_next;

    // captured transaction
    logic                    kind_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [MOVE_W-1:0]       move_reg;
    logic [DEPTH_W-1:0]      depth_reg;
    logic [TYPE_W-1:0]       type_reg;

    // pending match and response registers
    logic [MOVE_W-1:0]       found_move_reg;
    logic [DEPTH_W-1:0]      found_depth_reg;
    logic [TYPE_W-1:0]       found_type_reg;
    logic                    out_hit_reg;
    logic [MOVE_W-1:0]       out_move_reg;
    logic [DEPTH_W-1:0]      out_depth_reg;
    logic [TYPE_W-1:0]       out_type_reg;

    // ram ports
    logic                    meta_we;
    logic [INDEX_BITS-1:0]   meta_waddr;
    logic [META_W-1:0]       meta_wdata;
    logic [META_W-1:0]       meta_rdata;
    logic                    ent_we;
    logic                    ent_re;
    logic [ENT_ADDR_W-1:0]   ent_waddr;
    logic [ENT_ADDR_W-1:0]   ent_raddr;
    logic [ENT_W-1:0]        ent_wdata;
    logic [ENT_W-1:0]        ent_rdata;

    logic                    req_accept;
    logic                    out_load;
    logic [INDEX_BITS-1:0]   bucket;
    logic [TAG_W-1:0]        tag;
    logic [FILL_W-1:0]       meta_fill;
    logic [WAY_W-1:0]        meta_head;
    logic [WAY_W-1:0]        new_head;
    logic [FILL_W-1:0]       new_fill;
    logic [WAY_W:0]          way_wrap;
    logic [WAY_W-1:0]        way_sel;
    logic                    tag_match;
    logic                    scan_last;

    assign req_accept = req.valid && req.ready;
    assign req.ready  = (state_reg == ST_IDLE);

    assign bucket = key_reg[INDEX_BITS-1:0];
    assign tag    = key_reg[KEY_W-1:INDEX_BITS];

    // metadata word: fill count above head way
    assign meta_fill = meta_rdata[META_W-1 -: FILL_W];
    assign meta_head = meta_rdata[WAY_W-1:0];

    // store pushes one way past the current head, wrapping at the last way
    assign new_head = (meta_head == LAST_WAY) ? '0 : meta_head + WAY_W'(1);
    assign new_fill = (meta_fill == FULL) ? meta_fill : meta_fill + FILL_W'(1);

    // scan walks back from the head: way = (head - idx) mod WAYS
    assign way_wrap = {1'b0, head_reg} + WAYS_EXT - {1'b0, idx_reg};
    assign way_sel  = (head_reg >= idx_reg) ? (head_reg - idx_reg)
                                            : way_wrap[WAY_W-1:0];

    // the one shared tag comparator
    assign tag_match = (ent_rdata[ENT_W-1 -: TAG_W] == tag);
    assign scan_last = ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg);

    assign ent_waddr = {bucket, new_head};
    assign ent_raddr = {bucket, way_sel};
    assign ent_wdata = {tag, move_reg, type_reg, depth_reg};

    // bucket metadata: fill count and head way per bucket
    bbht_ram #(
        .WIDTH (META_W),
        .DEPTH (BUCKETS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata),
        .rd_en   (req_accept),
        .rd_addr (req.key[INDEX_BITS-1:0]),
        .rd_data (meta_rdata)
    );

    // entries: tag, move word and info per bucket way
    bbht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENT_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_en   (ent_re),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_load       = 1'b0;
        meta_we        = 1'b0;
        meta_waddr     = bucket;
        meta_wdata     = {new_fill, new_head};
        ent_we         = 1'b0;
        ent_re         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero one bucket's metadata a cycle
                meta_we      = 1'b1;
                meta_waddr   = clr_idx_reg;
                meta_wdata   = '0;
                clr_idx_next = clr_idx_reg + INDEX_BITS'(1);
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_META;
                end
            end

            ST_META:
            begin
                if (kind_reg == KIND_STORE)
                begin
                    // entry and metadata written back in the same cycle
                    meta_we    = 1'b1;
                    ent_we     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    head_next = meta_head;
                    fill_next = meta_fill;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    if (meta_fill == '0)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_ENT_RD;
                    end
                end
            end

            ST_ENT_RD:
            begin
                ent_re     = 1'b1;
                state_next = ST_ENT_CMP;
            end

            ST_ENT_CMP:
            begin
                if (tag_match)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_RESP;
                end
                else if (scan_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + WAY_W'(1);
                    state_next = ST_ENT_RD;
                end
            end

            ST_RESP:
            begin
                // load the response register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            kind_reg  <= req.kind;
            key_reg   <= req.key;
            move_reg  <= req.best_move;
            depth_reg <= req.search_depth;
            type_reg  <= req.bound_type;
        end
        if ((state_reg == ST_ENT_CMP) && tag_match)
        begin
            found_move_reg  <= ent_rdata[INFO_W +: MOVE_W];
            found_type_reg  <= ent_rdata[DEPTH_W +: TYPE_W];
            found_depth_reg <= ent_rdata[DEPTH_W-1:0];
        end
        if (out_load)
        begin
            // a miss reports zeros
            out_hit_reg   <= hit_reg;
            out_move_reg  <= hit_reg ? found_move_reg  : '0;
            out_depth_reg <= hit_reg ? found_depth_reg : '0;
            out_type_reg  <= hit_reg ? found_type_reg  : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.found_move  = out_move_reg;
    assign rsp.found_depth = out_depth_reg;
    assign rsp.found_type  = out_type_reg;

    // checks
    `ASSERT_SAME(a_clear_blocks_req, clk, rst_n, state_reg == ST_CLEAR, !req.ready,
        "transaction taken during metadata clearing pass")
    `ASSERT_NEXT(a_accept_reads_meta, clk, rst_n, req_accept, state_reg == ST_META,
        "accepted transaction did not move to metadata stage")
    `ASSERT_SAME(a_fill_bounded, clk, rst_n, state_reg == ST_META, meta_fill <= FULL,
        "bucket fill count above way count")
    `ASSERT_SAME(a_scan_in_fill, clk, rst_n, state_reg == ST_ENT_CMP,
        FILL_W'(idx_reg) < fill_reg, "scan beyond filled ways")

endmodule

`default_nettype wire

// File: tb/bbht_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbht_table_checker
// watches both channels of the bucket hash table, keeps its own copy of the
// buckets, predicts every lookup answer and compares the returned results
// ----------------------------------------------------------------------------

module bbht_table_checker import bbht_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bbht_in_if        req,
    bbht_out_if       rsp,
    output int        mismatches,
    output int        outstanding,
    output int        stores_seen,
    output int        full_stores,
    output int        lookups_seen,
    output int        hits_seen
);

    localparam int WAYS    = CHAIN_LIMIT_DEF + 1;
    localparam int BUCKETS = 1 << INDEX_BITS_DEF;
    localparam int TAG_W   = KEY_W - INDEX_BITS_DEF;

    typedef struct packed {
        logic               hit;
        logic [MOVE_W-1:0]  move_word;
        logic [DEPTH_W-1:0] depth;
        logic [TYPE_W-1:0]  bound;
    } lookup_answer_t;

    // bucket metadata, all buckets empty after reset
    int unsigned bucket_count  [BUCKETS];
    int unsigned bucket_newest [BUCKETS];

    // way contents, only ways counted by bucket_count are ever read
    logic [TAG_W-1:0]  way_tag  [int unsigned];
    logic [MOVE_W-1:0] way_move [int unsigned];
    logic [INFO_W-1:0] way_info [int unsigned];

    lookup_answer_t pending_answers [$];

    int err_count   = 0;
    int store_count = 0;
    int evict_count = 0;
    int probe_count = 0;
    int hit_count   = 0;

    assign mismatches   = err_count;
    assign outstanding  = pending_answers.size();
    assign stores_seen  = store_count;
    assign full_stores  = evict_count;
    assign lookups_seen = probe_count;
    assign hits_seen    = hit_count;

    // push a new entry at the head of its bucket, dropping the oldest when full
    task automatic record_store(input logic [KEY_W-1:0] key, input logic [MOVE_W-1:0] mv,
                                input logic [DEPTH_W-1:0] depth,
                                input logic [TYPE_W-1:0] bound);
        int unsigned bkt;
        int unsigned slot;
        bkt = 32'(key[INDEX_BITS_DEF-1:0]);
        if (bucket_count[bkt] == WAYS)
            evict_count++;
        bucket_newest[bkt] = (bucket_newest[bkt] + 1) % WAYS;
        slot = bkt * WAYS + bucket_newest[bkt];
        way_tag[slot]  = key[KEY_W-1:INDEX_BITS_DEF];
        way_move[slot] = mv;
        way_info[slot] = {bound, depth};
        if (bucket_count[bkt] < WAYS)
            bucket_count[bkt]++;
        store_count++;
    endtask

    // newest matching way of the bucket, or an all-zero miss
    function automatic lookup_answer_t predict_lookup(input logic [KEY_W-1:0] key);
        lookup_answer_t ans;
        int unsigned    bkt;
        int unsigned    way;
        int unsigned    slot;
        int unsigned    i;
        ans = '0;
        bkt = 32'(key[INDEX_BITS_DEF-1:0]);
        for (i = 0; i < bucket_count[bkt]; i++)
        begin
            way  = (bucket_newest[bkt] + WAYS - i) % WAYS;
            slot = bkt * WAYS + way;
            if (way_tag[slot] == key[KEY_W-1:INDEX_BITS_DEF])
            begin
                ans.hit       = 1'b1;
                ans.move_word = way_move[slot];
                ans.depth     = way_info[slot][DEPTH_W-1:0];
                ans.bound     = way_info[slot][INFO_W-1:DEPTH_W];
                break;
            end
        end
        return ans;
    endfunction

    task automatic check_answer(input lookup_answer_t got);
        lookup_answer_t exp;
        if (pending_answers.size() == 0)
        begin
            $display("%0t: result with no lookup outstanding: hit %b move %h depth %0d type %0d",
                     $time, got.hit, got.move_word, got.depth, got.bound);
            err_count++;
            return;
        end
        exp = pending_answers.pop_front();
        if (got.hit !== exp.hit)
        begin
            $display("%0t: hit expected %b actual %b", $time, exp.hit, got.hit);
            err_count++;
        end
        if (got.move_word !== exp.move_word)
        begin
            $display("%0t: found_move expected %h actual %h", $time, exp.move_word,
                     got.move_word);
            err_count++;
        end
        if (got.depth !== exp.depth)
        begin
            $display("%0t: found_depth expected %0d actual %0d", $time, exp.depth, got.depth);
            err_count++;
        end
        if (got.bound !== exp.bound)
        begin
            $display("%0t: found_type expected %0d actual %0d", $time, exp.bound, got.bound);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                check_answer('{rsp.hit, rsp.found_move, rsp.found_depth, rsp.found_type});
            if (req.valid && req.ready)
            begin
                if (req.kind == KIND_LOOKUP)
                begin
                    pending_answers.push_back(predict_lookup(req.key));
                    probe_count++;
                    if (pending_answers[$].hit)
                        hit_count++;
                end
                else
                    record_store(req.key, req.best_move, req.search_depth, req.bound_type);
            end
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the bounded bucket hash table: directed stores and
// lookups on edge keys, full buckets and duplicates, then bursty random
// traffic over a few hot buckets, with a stalling result receiver
// ----------------------------------------------------------------------------

module tb;

    import bbht_pkg::*;

    localparam int TAG_W       = KEY_W - INDEX_BITS_DEF;
    localparam int HOT_BUCKETS = 8;
    localparam int HOT_TAGS    = 6;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES = 400;

    // one request transaction as the sender sees it
    typedef struct {
        logic               kind;
        logic [KEY_W-1:0]   key;
        logic [MOVE_W-1:0]  best_move;
        logic [DEPTH_W-1:0] depth;
        logic [TYPE_W-1:0]  bound;
    } request_t;

    // receiver behaviour over a stretch of cycles
    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_LIGHT,
        RX_HEAVY,
        RX_HOLD
    } rx_style_t;

    logic clk;
    logic rst_n;

    int mismatches;
    int outstanding;
    int stores_seen;
    int full_stores;
    int lookups_seen;
    int hits_seen;

    bbht_in_if  req_if ();
    bbht_out_if rsp_if ();

    bounded_bucket_hash_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // watches both channels, predicts and compares
    bbht_table_checker CHK (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .stores_seen  (stores_seen),
        .full_stores  (full_stores),
        .lookups_seen (lookups_seen),
        .hits_seen    (hits_seen)
    );

    // hot buckets and their tag pools, so that random traffic keeps buckets
    // full, evicts, hits every way and misses within occupied buckets
    logic [INDEX_BITS_DEF-1:0] hot_bucket [HOT_BUCKETS];
    logic [TAG_W-1:0]          hot_tag    [HOT_BUCKETS][HOT_TAGS];

    request_t stimulus [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic request_t make_request(input logic kind, input logic [KEY_W-1:0] key,
                                              input logic [MOVE_W-1:0] mv,
                                              input logic [DEPTH_W-1:0] depth,
                                              input logic [TYPE_W-1:0] bound);
        request_t r;
        r.kind      = kind;
        r.key       = key;
        r.best_move = mv;
        r.depth     = depth;
        r.bound     = bound;
        return r;
    endfunction

    // mostly pool keys with random payload, some fully random keys as noise
    function automatic request_t random_request();
        request_t    r;
        logic [63:0] raw;
        int          b;
        r.kind      = 1'($urandom_range(0, 1));
        r.best_move = {$urandom, $urandom};
        r.depth     = 6'($urandom_range(0, 63));
        r.bound     = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 85)
        begin
            b     = $urandom_range(0, HOT_BUCKETS - 1);
            r.key = {hot_tag[b][$urandom_range(0, HOT_TAGS - 1)], hot_bucket[b]};
        end
        else
        begin
            raw   = {$urandom, $urandom};
            r.key = raw;
        end
        return r;
    endfunction

    // present one transaction and hold it until the block takes it
    task automatic offer(input request_t r);
        req_if.valid        <= 1'b1;
        req_if.kind         <= r.kind;
        req_if.key          <= r.key;
        req_if.best_move    <= r.best_move;
        req_if.search_depth <= r.depth;
        req_if.bound_type   <= r.bound;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // fixed chain of tags that overfills one bucket
    logic [TAG_W-1:0] chain_tag [5] = '{
        48'h0000_0000_0001, 48'h8000_0000_0000, 48'h5555_5555_5555,
        48'haaaa_aaaa_aaaa, 48'h0f0f_f0f0_0f0f
    };

    // result receiver: stretches of varying stall patterns, plus one long
    // hold-off once traffic is flowing so that the request side backs up
    initial
    begin
        rx_style_t style;
        int        stretch_left;
        int        taken;
        bit        held;
        style        = RX_OPEN;
        stretch_left = 0;
        taken        = 0;
        held         = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                taken++;
            if (stretch_left == 0)
            begin
                if (!held && taken >= 30)
                begin
                    style        = RX_HOLD;
                    stretch_left = HOLD_CYCLES;
                    held         = 1'b1;
                end
                else
                begin
                    style        = rx_style_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(5, 60);
                end
            end
            stretch_left--;
            case (style)
                RX_OPEN:  rsp_if.ready <= 1'b1;
                RX_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
                RX_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:  rsp_if.ready <= 1'b0;
            endcase
        end
    end

    // main sequence: reset, directed, random, drain, verdict
    initial
    begin
        logic [63:0] raw;
        int          burst;
        int          gap;

        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.kind         <= KIND_STORE;
        req_if.key          <= '0;
        req_if.best_move    <= '0;
        req_if.search_depth <= '0;
        req_if.bound_type   <= '0;

        // hot pool includes the lowest and highest bucket and the edge tags
        for (int b = 0; b < HOT_BUCKETS; b++)
        begin
            raw           = {$urandom, $urandom};
            hot_bucket[b] = raw[INDEX_BITS_DEF-1:0];
            for (int t = 0; t < HOT_TAGS; t++)
            begin
                raw          = {$urandom, $urandom};
                hot_tag[b][t] = raw[TAG_W-1:0];
            end
        end
        hot_bucket[0] = '0;
        hot_bucket[1] = '1;
        hot_tag[2][0] = '0;
        hot_tag[3][0] = '1;

        // lookup into an empty bucket misses
        stimulus.push_back(make_request(KIND_LOOKUP, 64'h0, '0, '0, '0));
        // all-ones payload at key zero, then read it back
        stimulus.push_back(make_request(KIND_STORE, 64'h0, '1, 6'd63, 2'd3));
        stimulus.push_back(make_request(KIND_LOOKUP, 64'h0, '0, '0, '0));
        // all-zero payload at the all-ones key: a hit whose fields are zero
        stimulus.push_back(make_request(KIND_STORE, '1, '0, 6'd0, 2'd0));
        stimulus.push_back(make_request(KIND_LOOKUP, '1, '0, '0, '0));
        // same bucket, other tag: miss in an occupied bucket
        stimulus.push_back(make_request(KIND_LOOKUP, 64'hffff_ffff_ffff_0000, '0, '0, '0));
        stimulus.push_back(make_request(KIND_LOOKUP, 64'h0000_0000_0000_ffff, '0, '0, '0));
        // duplicate keys: the newer copy wins
        stimulus.push_back(make_request(KIND_STORE, 64'h0123_4567_89ab_5a5a,
                                        64'h1111_2222_3333_4444, 6'd5, 2'd1));
        stimulus.push_back(make_request(KIND_STORE, 64'h0123_4567_89ab_5a5a,
                                        64'h5555_6666_7777_8888, 6'd9, 2'd2));
        stimulus.push_back(make_request(KIND_LOOKUP, 64'h0123_4567_89ab_5a5a, '0, '0, '0));
        // five stores into one bucket: the first is overwritten
        for (int i = 0; i < 5; i++)
        begin
            raw = {$urandom, $urandom};
            stimulus.push_back(make_request(KIND_STORE, {chain_tag[i], 16'h1234}, raw,
                                            6'(i * 13), 2'(i)));
        end
        stimulus.push_back(make_request(KIND_LOOKUP, {chain_tag[0], 16'h1234}, '0, '0, '0));
        stimulus.push_back(make_request(KIND_LOOKUP, {chain_tag[1], 16'h1234}, '0, '0, '0));
        stimulus.push_back(make_request(KIND_LOOKUP, {chain_tag[4], 16'h1234}, '0, '0, '0));
        stimulus.push_back(make_request(KIND_LOOKUP, {chain_tag[2], 16'h1234}, '0, '0, '0));
        // store fields on a lookup are ignored
        stimulus.push_back(make_request(KIND_LOOKUP, 64'h0, '1, 6'd63, 2'd3));

        for (int n = 0; n < RANDOM_ITEMS; n++)
            stimulus.push_back(random_request());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // bursts of back-to-back transactions with random gaps, the first
        // waits out the clearing pass behind req.ready
        while (stimulus.size() > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && stimulus.size() > 0)
            begin
                offer(stimulus.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && stimulus.size() > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_if.valid <= 1'b0;

        // drain: sample checker state away from the clock edge
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (24) @(posedge clk);

        $display("covered %0d stores (%0d into full buckets) and %0d lookups (%0d hits, %0d misses)",
                 stores_seen, full_stores, lookups_seen, hits_seen, lookups_seen - hits_seen);
        $display("with bursty requests, a stalling receiver and one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("bounded_bucket_hash_table: match");
        else
            $display("bounded_bucket_hash_table: mismatch");
        $finish;
    end

    // watchdog well beyond the clearing pass plus the slowest traffic
    initial
    begin
        #2000000;
        $display("bounded_bucket_hash_table: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bbht_pkg.sv
design/bbht_in_if.sv
design/bbht_out_if.sv
design/bbht_ram.sv
design/bounded_bucket_hash_table.sv
tb/bbht_table_checker.sv
tb/tb.sv
